// ----- rtl/kte_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kte_pkg
// Shared sizes, op codes and channel types of the keyed entry table.
// ----------------------------------------------------------------------------
package kte_pkg;

    localparam int ENTRIES      = 16;
    localparam int PAYLOAD_BITS = 64;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_LOOKUP = 3'd1;
    localparam logic [2:0] OP_STORE  = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_RMGRP  = 3'd4;
    localparam logic [2:0] OP_NTH    = 3'd5;
    localparam logic [2:0] OP_CLEAR  = 3'd6;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] group_key;
        logic [7:0]  entry_key;
        logic [7:0]  rank;
        logic [63:0] payload_in;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] group_out;
        logic [7:0]  entry_out;
        logic [63:0] payload_out;
        logic [4:0]  valid_count;
    } rsp_t;

    typedef struct packed {
        logic             load;
        logic             scan;
        logic             commit;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic skip_scan;
    } sts_t;

endpackage

// ----- rtl/kte_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kte_ctrl
// Sequencer: accept a command, step the slot scan, commit, hand off result.
// ----------------------------------------------------------------------------
module kte_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  kte_pkg::sts_t sts,
    output kte_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT, S_DONE} state_t;

    state_t                    state_reg;
    logic [kte_pkg::IDX_W-1:0] idx_reg;
    logic                      in_ready_reg;
    logic                      out_valid_reg;

    localparam logic [kte_pkg::IDX_W-1:0] LAST_IDX = kte_pkg::IDX_W'(kte_pkg::ENTRIES - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg    <= S_SCAN;
                        idx_reg      <= '0;
                        in_ready_reg <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    if (sts.skip_scan || idx_reg == LAST_IDX)
                        state_reg <= S_COMMIT;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_COMMIT:
                begin
                    state_reg     <= S_DONE;
                    out_valid_reg <= 1'b1;
                end
                S_DONE:
                begin
                    if (out_ready)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b0;
                        in_ready_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready   = in_ready_reg;
    assign out_valid  = out_valid_reg;
    assign cmd.load   = in_valid && in_ready_reg;
    assign cmd.scan   = (state_reg == S_SCAN) && !sts.skip_scan;
    assign cmd.commit = (state_reg == S_COMMIT);
    assign cmd.idx    = idx_reg;

endmodule

// ----- rtl/kte_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kte_datapath
// Slot storage, per-slot compare during the scan, and the commit of updates.
// ----------------------------------------------------------------------------
module kte_datapath
(
    input  logic          clk,
    input  logic          rst_n,
    input  kte_pkg::req_t req,
    input  kte_pkg::cmd_t cmd,
    output kte_pkg::sts_t sts,
    output kte_pkg::rsp_t rsp
);

    localparam int IW = kte_pkg::IDX_W;
    localparam int CW = kte_pkg::CNT_W;
    localparam int PW = kte_pkg::PAYLOAD_BITS;
    localparam int RW = CW + 8;

    // slot store
    logic [kte_pkg::ENTRIES-1:0] valid_reg;
    logic [15:0]                 gkey_mem [kte_pkg::ENTRIES];
    logic [7:0]                  ekey_mem [kte_pkg::ENTRIES];
    logic [PW-1:0]               pay_mem  [kte_pkg::ENTRIES];
    logic [CW-1:0]               count_reg;

    // latched request
    logic [2:0]    op_reg;
    logic [15:0]   gkey_reg;
    logic [7:0]    ekey_reg;
    logic [7:0]    rank_reg;
    logic [PW-1:0] pay_reg;

    // scan results
    logic          hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic          free_reg;
    logic [IW-1:0] free_idx_reg;
    logic          nth_reg;
    logic [CW-1:0] seen_reg;
    logic          any_reg;
    logic [15:0]   gcap_reg;
    logic [7:0]    ecap_reg;
    logic [PW-1:0] pcap_reg;

    kte_pkg::rsp_t rsp_reg;

    // slot under scan
    logic slot_v;
    logic slot_gm;
    logic slot_match;
    logic rank_eq;

    assign slot_v     = valid_reg[cmd.idx];
    assign slot_gm    = gkey_mem[cmd.idx] == gkey_reg;
    assign slot_match = slot_v && slot_gm && (ekey_mem[cmd.idx] == ekey_reg);
    assign rank_eq    = RW'(seen_reg) == RW'(rank_reg);

    // commit decode
    logic          ok_c;
    logic          rd_c;
    logic          set_v;
    logic          clr_v;
    logic          clr_all;
    logic          pay_we;
    logic          key_we;
    logic [IW-1:0] wr_idx;
    logic          cnt_inc;
    logic          cnt_dec;
    logic [CW-1:0] count_commit;

    always_comb
    begin
        ok_c    = 1'b0;
        rd_c    = 1'b0;
        set_v   = 1'b0;
        clr_v   = 1'b0;
        clr_all = 1'b0;
        pay_we  = 1'b0;
        key_we  = 1'b0;
        wr_idx  = hit_idx_reg;
        cnt_inc = 1'b0;
        cnt_dec = 1'b0;
        unique case (op_reg)
            kte_pkg::OP_ADD:
            begin
                if (hit_reg)
                begin
                    ok_c   = 1'b1;
                    pay_we = 1'b1;
                end
                else if (free_reg)
                begin
                    ok_c    = 1'b1;
                    wr_idx  = free_idx_reg;
                    pay_we  = 1'b1;
                    key_we  = 1'b1;
                    set_v   = 1'b1;
                    cnt_inc = 1'b1;
                end
            end
            kte_pkg::OP_LOOKUP:
            begin
                ok_c = hit_reg;
                rd_c = 1'b1;
            end
            kte_pkg::OP_STORE:
            begin
                ok_c   = hit_reg;
                pay_we = hit_reg;
            end
            kte_pkg::OP_REMOVE:
            begin
                ok_c    = hit_reg;
                clr_v   = hit_reg;
                cnt_dec = hit_reg;
            end
            kte_pkg::OP_RMGRP:
            begin
                ok_c = any_reg;
            end
            kte_pkg::OP_NTH:
            begin
                ok_c = nth_reg;
                rd_c = 1'b1;
            end
            kte_pkg::OP_CLEAR:
            begin
                ok_c    = 1'b1;
                clr_all = 1'b1;
            end
            default:
            begin
                ok_c = 1'b0;
            end
        endcase

        priority if (clr_all)
            count_commit = '0;
        else if (cnt_inc)
            count_commit = count_reg + 1'b1;
        else if (cnt_dec)
            count_commit = count_reg - 1'b1;
        else
            count_commit = count_reg;
    end

    // control state: valid marks, count, scan flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            nth_reg   <= 1'b0;
            any_reg   <= 1'b0;
            seen_reg  <= '0;
        end
        else if (cmd.load)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            nth_reg  <= 1'b0;
            any_reg  <= 1'b0;
            seen_reg <= '0;
        end
        else if (cmd.scan)
        begin
            if (slot_match && !hit_reg)
                hit_reg <= 1'b1;
            if (!slot_v && !free_reg)
                free_reg <= 1'b1;
            if (op_reg == kte_pkg::OP_NTH && slot_v && !nth_reg)
            begin
                if (rank_eq)
                    nth_reg <= 1'b1;
                else
                    seen_reg <= seen_reg + 1'b1;
            end
            // group drop happens in place as the scan walks the slots
            if (op_reg == kte_pkg::OP_RMGRP && slot_v && slot_gm)
            begin
                valid_reg[cmd.idx] <= 1'b0;
                any_reg            <= 1'b1;
                count_reg          <= count_reg - 1'b1;
            end
        end
        else if (cmd.commit)
        begin
            if (clr_all)
                valid_reg <= '0;
            else if (set_v)
                valid_reg[wr_idx] <= 1'b1;
            else if (clr_v)
                valid_reg[wr_idx] <= 1'b0;
            count_reg <= count_commit;
        end
    end

    // payload side: request, captures, slot data, result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= req.op;
            gkey_reg <= req.group_key;
            ekey_reg <= req.entry_key;
            rank_reg <= req.rank;
            pay_reg  <= req.payload_in[PW-1:0];
            gcap_reg <= '0;
            ecap_reg <= '0;
            pcap_reg <= '0;
        end
        else if (cmd.scan)
        begin
            if (slot_match && !hit_reg)
            begin
                hit_idx_reg <= cmd.idx;
                if (op_reg == kte_pkg::OP_LOOKUP)
                begin
                    gcap_reg <= gkey_mem[cmd.idx];
                    ecap_reg <= ekey_mem[cmd.idx];
                    pcap_reg <= pay_mem[cmd.idx];
                end
            end
            if (!slot_v && !free_reg)
                free_idx_reg <= cmd.idx;
            if (op_reg == kte_pkg::OP_NTH && slot_v && !nth_reg && rank_eq)
            begin
                gcap_reg <= gkey_mem[cmd.idx];
                ecap_reg <= ekey_mem[cmd.idx];
                pcap_reg <= pay_mem[cmd.idx];
            end
        end
        else if (cmd.commit)
        begin
            if (pay_we)
                pay_mem[wr_idx] <= pay_reg;
            if (key_we)
            begin
                gkey_mem[wr_idx] <= gkey_reg;
                ekey_mem[wr_idx] <= ekey_reg;
            end
            rsp_reg.ok          <= ok_c;
            rsp_reg.group_out   <= rd_c ? gcap_reg : 16'd0;
            rsp_reg.entry_out   <= rd_c ? ecap_reg : 8'd0;
            rsp_reg.payload_out <= rd_c ? 64'(pcap_reg) : 64'd0;
            rsp_reg.valid_count <= 5'(count_commit);
        end
    end

    // clear and unused codes need no slot walk
    assign sts.skip_scan = (op_reg == kte_pkg::OP_CLEAR) || (op_reg > kte_pkg::OP_CLEAR);
    assign rsp           = rsp_reg;

endmodule

// ----- rtl/keyed_entry_table_top.sv -----
`timescale 1ns / 1ps
// Each command is accepted, then the slots are scanned in turn, one slot per cycle,
//   then the update is committed and out_valid raised; clear and unused op codes
//   skip the scan. Only one command is in flight: in_ready returns after the result
//   is taken by out_ready.
// Reset: rst_n clears all valid marks and the occupancy count at once; keys and
//   payloads are not cleared and are only read from valid slots.
// ----------------------------------------------------------------------------
// keyed_entry_table_top
// Fixed-size keyed table: add, lookup, store, remove, group remove, nth, clear.
// ----------------------------------------------------------------------------
module keyed_entry_table_top
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  kte_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output kte_pkg::rsp_t out_data
);

    kte_pkg::cmd_t cmd;
    kte_pkg::sts_t sts;

    kte_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    kte_datapath u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (in_data),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (out_data)
    );

    // one command in flight: no intake while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("in_ready and out_valid high together");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while busy");

    a_miss_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.ok) |->
            (out_data.group_out == 16'd0 && out_data.entry_out == 8'd0
             && out_data.payload_out == 64'd0))
        else $error("failed command returned nonzero data");

endmodule

// ----- tb/keyed_entry_table_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_entry_table_top_tb
// Self-checking bench for the keyed entry table. A short table of directed
// commands (empty table, key extremes, misses, full table, unused op, clear)
// is followed by random command streams over a small key space so entries
// collide, fill the table and get removed. A shadow table predicts each
// response not typed in by hand; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module keyed_entry_table_top_tb;

    import kte_pkg::*;

    localparam logic [2:0]  OP_UNUSED   = 3'd7;
    localparam int          RAND_CMDS   = 1550;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam logic [63:0] PAY_MASK    = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - PAYLOAD_BITS);
    localparam logic [63:0] ONES64      = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam rsp_t        NO_RSP      = '0;

    typedef struct {
        req_t cmd;
        bit   typed;
        rsp_t want;
    } probe_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic out_ready = 1'b0;
    req_t in_data   = '0;
    logic in_ready;
    logic out_valid;
    rsp_t out_data;

    // shadow copy of the table
    bit          tbl_valid [ENTRIES];
    logic [15:0] tbl_group [ENTRIES];
    logic [7:0]  tbl_entry [ENTRIES];
    logic [63:0] tbl_pay   [ENTRIES];

    rsp_t   expected_rsp_q[$];
    probe_t probes[$];
    int     errors     = 0;
    int     cycle_cnt  = 0;
    int     idle_pct   = 30;
    int     stall_left = 0;
    rsp_t   want;

    keyed_entry_table_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #4 clk = ~clk;

    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 75)
            return $urandom_range(1, 3);
        else if (p < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int find_key(logic [15:0] g, logic [7:0] e);
        int i;
        for (i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_group[i] == g && tbl_entry[i] == e)
                return i;
        return -1;
    endfunction

    // applies one command to the shadow table and returns its response
    function automatic rsp_t table_apply(req_t c);
        rsp_t r;
        int   i;
        int   slot;
        int   seen;
        int   n;
        r    = '0;
        seen = 0;
        n    = 0;
        slot = find_key(c.group_key, c.entry_key);
        case (c.op)
            OP_ADD:
            begin
                if (slot < 0)
                begin
                    for (i = ENTRIES - 1; i >= 0; i--)
                        if (!tbl_valid[i])
                            slot = i;
                    if (slot >= 0)
                    begin
                        tbl_group[slot] = c.group_key;
                        tbl_entry[slot] = c.entry_key;
                    end
                end
                if (slot >= 0)
                begin
                    tbl_pay[slot]   = c.payload_in & PAY_MASK;
                    tbl_valid[slot] = 1'b1;
                    r.ok            = 1'b1;
                end
            end
            OP_LOOKUP:
            begin
                if (slot >= 0)
                begin
                    r.ok          = 1'b1;
                    r.group_out   = tbl_group[slot];
                    r.entry_out   = tbl_entry[slot];
                    r.payload_out = tbl_pay[slot];
                end
            end
            OP_STORE:
            begin
                if (slot >= 0)
                begin
                    tbl_pay[slot] = c.payload_in & PAY_MASK;
                    r.ok          = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (slot >= 0)
                begin
                    tbl_valid[slot] = 1'b0;
                    r.ok            = 1'b1;
                end
            end
            OP_RMGRP:
            begin
                for (i = 0; i < ENTRIES; i++)
                    if (tbl_valid[i] && tbl_group[i] == c.group_key)
                    begin
                        tbl_valid[i] = 1'b0;
                        r.ok         = 1'b1;
                    end
            end
            OP_NTH:
            begin
                for (i = 0; i < ENTRIES; i++)
                    if (tbl_valid[i])
                    begin
                        if (seen == int'(c.rank) && !r.ok)
                        begin
                            r.ok          = 1'b1;
                            r.group_out   = tbl_group[i];
                            r.entry_out   = tbl_entry[i];
                            r.payload_out = tbl_pay[i];
                        end
                        seen++;
                    end
            end
            OP_CLEAR:
            begin
                for (i = 0; i < ENTRIES; i++)
                    tbl_valid[i] = 1'b0;
                r.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        for (i = 0; i < ENTRIES; i++)
            if (tbl_valid[i])
                n++;
        r.valid_count = n[4:0];
        return r;
    endfunction

    // mostly keys that exist or collide; some fully random
    function automatic req_t random_cmd();
        req_t c;
        int   p;
        int   i;
        int   live[$];
        p = $urandom_range(0, 99);
        if (p < 35)
            c.op = OP_ADD;
        else if (p < 55)
            c.op = OP_LOOKUP;
        else if (p < 65)
            c.op = OP_STORE;
        else if (p < 77)
            c.op = OP_REMOVE;
        else if (p < 81)
            c.op = OP_RMGRP;
        else if (p < 93)
            c.op = OP_NTH;
        else if (p < 95)
            c.op = OP_CLEAR;
        else if (p < 97)
            c.op = OP_UNUSED;
        else
            c.op = OP_ADD;
        for (i = 0; i < ENTRIES; i++)
            if (tbl_valid[i])
                live.push_back(i);
        p = $urandom_range(0, 99);
        if (live.size() > 0 && p < 35)
        begin
            i           = live[$urandom_range(0, live.size() - 1)];
            c.group_key = tbl_group[i];
            c.entry_key = tbl_entry[i];
        end
        else if (p < 85)
        begin
            case ($urandom_range(0, 3))
                0: c.group_key = 16'h0000;
                1: c.group_key = 16'h00A5;
                2: c.group_key = 16'h8001;
                default: c.group_key = 16'hFFFF;
            endcase
            c.entry_key = 8'($urandom_range(0, 5));
        end
        else
        begin
            c.group_key = 16'($urandom);
            c.entry_key = 8'($urandom);
        end
        c.rank       = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 17)) : 8'($urandom);
        c.payload_in = {$urandom, $urandom};
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    function automatic void add_probe(req_t c, bit typed, rsp_t r);
        probe_t pr;
        pr.cmd   = c;
        pr.typed = typed;
        pr.want  = r;
        probes.push_back(pr);
    endfunction

    // one input transfer; the expectation is queued at the accepting edge
    task automatic send_cmd(input req_t c, input bit typed, input rsp_t typed_rsp);
        int   gap;
        rsp_t pred;
        gap = ($urandom_range(0, 99) < idle_pct) ? idle_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= c;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pred = table_apply(c);
        expected_rsp_q.push_back(typed ? typed_rsp : pred);
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 99) < idle_pct)
                stall_left = idle_len();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_rsp_q.size() == 0)
                report_mismatch("response transfer with nothing outstanding");
            else
            begin
                want = expected_rsp_q.pop_front();
                if (out_data.ok !== want.ok)
                    report_mismatch($sformatf("ok got %b want %b", out_data.ok, want.ok));
                if (out_data.group_out !== want.group_out)
                    report_mismatch($sformatf("group_out got %h want %h",
                                              out_data.group_out, want.group_out));
                if (out_data.entry_out !== want.entry_out)
                    report_mismatch($sformatf("entry_out got %h want %h",
                                              out_data.entry_out, want.entry_out));
                if (out_data.payload_out !== want.payload_out)
                    report_mismatch($sformatf("payload_out got %h want %h",
                                              out_data.payload_out, want.payload_out));
                if (out_data.valid_count !== want.valid_count)
                    report_mismatch($sformatf("valid_count got %0d want %0d",
                                              out_data.valid_count, want.valid_count));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int k;
        for (k = 0; k < ENTRIES; k++)
            tbl_valid[k] = 1'b0;

        // empty table, misses, key extremes
        add_probe(req_t'{OP_LOOKUP, 16'h0000, 8'h00, 8'h00, 64'h0}, 1'b1, NO_RSP);
        add_probe(req_t'{OP_NTH, 16'h0000, 8'h00, 8'h00, 64'h0}, 1'b1, NO_RSP);
        add_probe(req_t'{OP_RMGRP, 16'h1234, 8'h00, 8'h00, 64'h0}, 1'b1, NO_RSP);
        add_probe(req_t'{OP_STORE, 16'h0000, 8'h00, 8'h00, ONES64}, 1'b1, NO_RSP);
        add_probe(req_t'{OP_REMOVE, 16'hFFFF, 8'hFF, 8'h00, 64'h0}, 1'b1, NO_RSP);
        add_probe(req_t'{OP_ADD, 16'hFFFF, 8'hFF, 8'hFF, ONES64}, 1'b1,
                  rsp_t'{1'b1, 16'h0, 8'h0, 64'h0, 5'd1});
        add_probe(req_t'{OP_LOOKUP, 16'hFFFF, 8'hFF, 8'h00, 64'h0}, 1'b1,
                  rsp_t'{1'b1, 16'hFFFF, 8'hFF, ONES64 & PAY_MASK, 5'd1});
        add_probe(req_t'{OP_ADD, 16'h0000, 8'h00, 8'h00, 64'h0}, 1'b1,
                  rsp_t'{1'b1, 16'h0, 8'h0, 64'h0, 5'd2});
        add_probe(req_t'{OP_ADD, 16'hFFFF, 8'hFF, 8'h00, 64'h0123_4567_89AB_CDEF},
                  1'b0, NO_RSP);
        add_probe(req_t'{OP_STORE, 16'h0000, 8'h00, 8'h00, 64'hA5A5_5A5A_F00F_0FF0},
                  1'b0, NO_RSP);
        add_probe(req_t'{OP_NTH, 16'h0000, 8'h00, 8'h01, 64'h0}, 1'b0, NO_RSP);
        add_probe(req_t'{OP_NTH, 16'h0000, 8'h00, 8'hFF, 64'h0}, 1'b1,
                  rsp_t'{1'b0, 16'h0, 8'h0, 64'h0, 5'd2});
        add_probe(req_t'{OP_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, ONES64}, 1'b1,
                  rsp_t'{1'b0, 16'h0, 8'h0, 64'h0, 5'd2});
        add_probe(req_t'{OP_RMGRP, 16'h0000, 8'h00, 8'h00, 64'h0}, 1'b0, NO_RSP);
        // fill up from one entry, then add to a full table
        for (k = 0; k < ENTRIES - 1; k++)
            add_probe(req_t'{OP_ADD, 16'h0100 + 16'(k % 3), 8'(k), 8'h00, {$urandom, $urandom}},
                      1'b0, NO_RSP);
        add_probe(req_t'{OP_ADD, 16'h7777, 8'h77, 8'h00, ONES64}, 1'b1,
                  rsp_t'{1'b0, 16'h0, 8'h0, 64'h0, 5'(ENTRIES)});
        add_probe(req_t'{OP_CLEAR, 16'h0000, 8'h00, 8'h00, 64'h0}, 1'b1,
                  rsp_t'{1'b1, 16'h0, 8'h0, 64'h0, 5'd0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (probes[j])
            send_cmd(probes[j].cmd, probes[j].typed, probes[j].want);

        for (k = 0; k < RAND_CMDS; k++)
        begin
            if (k % 150 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 25;
                    default: idle_pct = 60;
                endcase
            end
            // hold off until the table has answered everything
            if (k > 0 && k % 400 == 0)
            begin
                in_valid <= 1'b0;
                while (expected_rsp_q.size() != 0)
                    @(posedge clk);
            end
            send_cmd(random_cmd(), 1'b0, NO_RSP);
        end
        in_valid <= 1'b0;

        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (2 * ENTRIES + 8) @(posedge clk);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
